// ----- sv/running_median_two_heaps_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the running median block
// Concurrent checks that vanish when the design is synthesised.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH
`ifndef SYNTHESIS
`define RMTH_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define RMTH_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define RMTH_ASSERT(lbl, ck, rs, prop, msg)
`define RMTH_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

// ----- sv/rmth_pkg.sv -----
// ----------------------------------------------------------------------------
// Running median package
// Sequencer states shared by the running median block.
// ----------------------------------------------------------------------------
package rmth_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MV_RD,
    ST_MV_WAIT,
    ST_PS_RD,
    ST_PS_CMP,
    ST_TOP_RD,
    ST_TOP_WAIT,
    ST_OUT
  } state_t;

  localparam int unsigned COUNT_BITS = 9;

endpackage

// ----- sv/rmth_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rmth_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/running_median_two_heaps.sv -----
// ----------------------------------------------------------------------------
// Running median over two sorted stores
// Keeps the lower half of the samples in an ascending memory and the upper
// half in a descending memory and returns twice the median after each sample.
//
//   Channel   Direction  tdata (low bit up)               tuser
//   s_        in         sample                           -
//   m_        out        median_x2, held_count            dropped
//
// A push walks its store from the top down, shifting each entry it passes up
// a slot, and writes the value where it stops; a top moving across adds a
// second push. The result is offered after both tops are read, or in the
// cycle after acceptance for a dropped sample. One transaction is in work at
// a time, and the next is taken in the cycle after the result is accepted.
// Reset empties both stores; memory contents need no clearing.
// ----------------------------------------------------------------------------
`include "running_median_two_heaps_assert.svh"

module running_median_two_heaps
  import rmth_pkg::*;
#(
  parameter int CAPACITY    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // sample
  output logic m_tvalid,
  input  logic m_tready,
  output logic [((SAMPLE_BITS+1+COUNT_BITS+7)/8)*8-1:0] m_tdata,  // median_x2, held_count
  output logic m_tuser  // dropped
);

  localparam int SB      = SAMPLE_BITS;
  localparam int MW      = SB + 1;
  localparam int DEPTH   = (CAPACITY + 1) / 2;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int TW      = CW + 1;
  localparam int OW      = ((MW + COUNT_BITS + 7) / 8) * 8;

  state_t state, state_next;

  logic signed [SB-1:0] sample;
  logic signed [SB-1:0] val;
  logic [CW-1:0]        lc, uc, idx;
  logic                 cur_upper, push_upper, move_from_upper, second;
  logic signed [MW-1:0] median;
  logic                 dropped;

  logic          lo_we, up_we;
  logic [AW-1:0] lo_waddr, up_waddr, lo_raddr, up_raddr;
  logic [SB-1:0] lo_wdata, up_wdata, lo_rdata, up_rdata;

  logic signed [SB-1:0] s_in, rd_cur, lt, ut;
  logic signed [MW-1:0] s2, med_new;
  logic [TW-1:0]        total;
  logic                 full, shift, idx_zero;
  logic [CW-1:0]        idx_dec;

  assign s_in     = s_tdata[SB-1:0];
  assign s2       = {s_in, 1'b0};
  assign total    = TW'(lc) + TW'(uc);
  assign full     = total >= TW'(CAPACITY);
  assign rd_cur   = cur_upper ? up_rdata : lo_rdata;
  assign shift    = cur_upper ? (rd_cur < val) : (rd_cur > val);
  assign idx_zero = idx == '0;
  assign idx_dec  = idx - 1'b1;
  assign lt       = (lc != '0) ? signed'(lo_rdata) : '0;
  assign ut       = (uc != '0) ? signed'(up_rdata) : '0;

  always_comb begin
    if (lc == uc) begin
      med_new = {lt[SB-1], lt} + {ut[SB-1], ut};
    end else if (lc < uc) begin
      med_new = {ut, 1'b0};
    end else begin
      med_new = {lt, 1'b0};
    end
  end

  always_comb begin
    state_next = state;
    lo_we = 1'b0;
    up_we = 1'b0;
    lo_waddr = idx[AW-1:0];
    up_waddr = idx[AW-1:0];
    lo_wdata = val;
    up_wdata = val;
    lo_raddr = idx_dec[AW-1:0];
    up_raddr = idx_dec[AW-1:0];
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (full) begin
            state_next = ST_OUT;
          end else if (lc == '0 || lc == uc) begin
            state_next = ST_PS_RD;
          end else if ((lc < uc && s2 > median) || (lc > uc && s2 < median)) begin
            state_next = ST_MV_RD;
          end else begin
            state_next = ST_PS_RD;
          end
        end
      end
      ST_MV_RD: begin
        lo_raddr = AW'(lc - 1'b1);
        up_raddr = AW'(uc - 1'b1);
        state_next = ST_MV_WAIT;
      end
      ST_MV_WAIT: state_next = ST_PS_RD;
      ST_PS_RD: begin
        if (idx_zero) begin
          lo_we = !cur_upper;
          up_we = cur_upper;
          state_next = second ? ST_PS_RD : ST_TOP_RD;
        end else begin
          state_next = ST_PS_CMP;
        end
      end
      ST_PS_CMP: begin
        lo_we = !cur_upper;
        up_we = cur_upper;
        if (shift) begin
          lo_wdata = lo_rdata;
          up_wdata = up_rdata;
          state_next = ST_PS_RD;
        end else begin
          state_next = second ? ST_PS_RD : ST_TOP_RD;
        end
      end
      ST_TOP_RD: begin
        lo_raddr = AW'(lc - 1'b1);
        up_raddr = AW'(uc - 1'b1);
        state_next = ST_TOP_WAIT;
      end
      ST_TOP_WAIT: state_next = ST_OUT;
      ST_OUT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lc <= '0;
      uc <= '0;
      second <= 1'b0;
      median <= '0;
      dropped <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          sample <= s_in;
          val <= s_in;
          dropped <= full;
          second <= 1'b0;
          if (lc == '0 || (lc == uc && s2 <= median) || (lc < uc && s2 <= median)
              || (lc > uc && s2 < median)) begin
            push_upper <= 1'b0;
            cur_upper <= 1'b0;
            idx <= lc;
          end else begin
            push_upper <= 1'b1;
            cur_upper <= 1'b1;
            idx <= uc;
          end
          move_from_upper <= lc < uc;
        end
        ST_MV_WAIT: begin
          second <= 1'b1;
          cur_upper <= !move_from_upper;
          if (move_from_upper) begin
            val <= up_rdata;
            uc <= uc - 1'b1;
            idx <= lc;
          end else begin
            val <= lo_rdata;
            lc <= lc - 1'b1;
            idx <= uc;
          end
        end
        ST_PS_RD, ST_PS_CMP: begin
          if (state == ST_PS_CMP && shift) begin
            idx <= idx_dec;
          end else if (state == ST_PS_CMP || idx_zero) begin
            if (cur_upper) begin
              uc <= uc + 1'b1;
            end else begin
              lc <= lc + 1'b1;
            end
            if (second) begin
              second <= 1'b0;
              cur_upper <= push_upper;
              val <= sample;
              idx <= push_upper ? uc : lc;
            end
          end
        end
        ST_TOP_WAIT: median <= med_new;
        default: begin
        end
      endcase
    end
  end

  rmth_ram #(.WIDTH(SB), .DEPTH(DEPTH), .AW(AW)) u_lower (
    .clk(clk), .we(lo_we), .waddr(lo_waddr), .wdata(lo_wdata),
    .raddr(lo_raddr), .rdata(lo_rdata)
  );

  rmth_ram #(.WIDTH(SB), .DEPTH(DEPTH), .AW(AW)) u_upper (
    .clk(clk), .we(up_we), .waddr(up_waddr), .wdata(up_wdata),
    .raddr(up_raddr), .rdata(up_rdata)
  );

  assign s_tready = state == ST_IDLE;
  assign m_tvalid = state == ST_OUT;
  assign m_tuser  = dropped;
  assign m_tdata  = OW'({COUNT_BITS'(total), median});

  `RMTH_ASSERT(a_balance, clk, rst, (lc == uc) || (lc == uc + 1'b1) || (uc == lc + 1'b1),
    "store sizes differ by more than one")
  `RMTH_ASSERT(a_one_at_a_time, clk, rst, !(s_tready && m_tvalid),
    "input taken while a result waits")
  `RMTH_ASSERT(a_drop_full, clk, rst, (m_tvalid && m_tuser) |-> full,
    "dropped flag without full stores")
  `RMTH_ASSERT(a_depth, clk, rst, (lc <= CW'(DEPTH)) && (uc <= CW'(DEPTH)),
    "store count beyond depth")

endmodule
